[sv/grdc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the grid ray caster.
// No dependencies; imported by every module of the block but grdc_ram.
package grdc_pkg;

	localparam int FRAC      = 16;            // fraction bits of every fixed-point value
	localparam int TILE_W    = 6;             // bits of a tile index
	localparam int MAP_W     = 64;            // map columns
	localparam int MAP_H     = 64;            // map rows
	localparam int MAP_DEPTH = MAP_W * MAP_H;
	localparam int ADDR_W    = 2 * TILE_W;
	localparam int CELL_W    = 8;
	localparam int POS_W     = 22;            // Q6.16 unsigned
	localparam int VEC_W     = 19;            // Q2.16 signed
	localparam int SCL_W     = 18;            // Q1.16 signed
	localparam int PROD_W    = VEC_W + SCL_W;
	localparam int RAY_W     = 21;            // ray component, signed
	localparam int MAG_W     = 21;            // |ray component|
	localparam int DELTA_W   = 2 * FRAC + 1; // 2^32 / |r|
	localparam int EDGE_W    = FRAC + 1;      // distance to first edge in tiles
	localparam int DIST_W    = 40;            // running edge distance
	localparam int OUT_D_W   = 24;            // reported distance
	localparam int MAX_STEPS = MAP_W + MAP_H;
	localparam int STEP_CW   = 8;             // step counter, holds MAX_STEPS
	localparam int CFG_IDX_W = 3;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POS_X   = 3'd0,
		CFG_POS_Y   = 3'd1,
		CFG_DIR_X   = 3'd2,
		CFG_DIR_Y   = 3'd3,
		CFG_PLANE_X = 3'd4,
		CFG_PLANE_Y = 3'd5
	} cfg_idx_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_WRITE,
		OP_CAST,
		OP_SUM,
		OP_DIV_START,
		OP_DIV_TAKE,
		OP_EDGE_LO,
		OP_EDGE_HI,
		OP_STEP,
		OP_CHECK,
		OP_LOAD
	} op_t;

	typedef struct packed {
		op_t  op;
		logic sel;      // axis: 0 = x, 1 = y
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_busy;
		logic out_full;
		logic oob;
		logic wall_nz;
		logic steps_last;
	} sts_t;

endpackage

[sv/grdc_ram.sv]
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module grdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/grdc_div.sv]
`timescale 1ns / 1ps
// Restoring divider: 2^(2*FRAC) / divisor, one quotient bit per cycle.
// Depends on grdc_pkg.
module grdc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [grdc_pkg::MAG_W-1:0]   divisor,
	output logic                         busy,
	output logic [grdc_pkg::DELTA_W-1:0] quotient
);
	import grdc_pkg::*;

	localparam int CNT_W = $clog2(DELTA_W + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic [DELTA_W-1:0] dvd_q;
	logic [MAG_W-1:0]   rem_q;
	logic [MAG_W:0]     trial;
	logic               fits;

	// shift in the next dividend bit and test against the divisor
	assign trial = {rem_q, dvd_q[DELTA_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DELTA_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q    <= {1'b1, {(DELTA_W-1){1'b0}}};
			rem_q    <= '0;
		end else if (cnt_q != '0) begin
			dvd_q    <= {dvd_q[DELTA_W-2:0], fits};
			rem_q    <= fits ? MAG_W'(trial - {1'b0, divisor}) : trial[MAG_W-1:0];
		end
	end

	// dividend bits shift out as quotient bits shift in
	assign quotient = dvd_q;
	assign busy     = cnt_q != '0;

endmodule

[sv/grdc_datapath.sv]
`timescale 1ns / 1ps
// Datapath: configuration registers, map memory, ray setup, stepping, result.
// Depends on grdc_pkg, grdc_ram and grdc_div.
module grdc_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  grdc_pkg::cmd_t                  cmd,
	output grdc_pkg::sts_t                  sts,
	input  logic [grdc_pkg::IN_DATA_W-1:0]  in_data,
	input  logic                            cfg_we,
	input  logic [grdc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [grdc_pkg::POS_W-1:0]      cfg_wdata,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [grdc_pkg::OUT_DATA_W-1:0] out_data
);
	import grdc_pkg::*;

	// configuration
	logic [POS_W-1:0]        pos_x_q, pos_y_q;
	logic signed [VEC_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= POS_W'(98304);
			pos_y_q   <= POS_W'(98304);
			dir_x_q   <= VEC_W'(65536);
			dir_y_q   <= '0;
			plane_x_q <= '0;
			plane_y_q <= -VEC_W'(43254);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_POS_X:   pos_x_q   <= cfg_wdata;
				CFG_POS_Y:   pos_y_q   <= cfg_wdata;
				CFG_DIR_X:   dir_x_q   <= cfg_wdata[VEC_W-1:0];
				CFG_DIR_Y:   dir_y_q   <= cfg_wdata[VEC_W-1:0];
				CFG_PLANE_X: plane_x_q <= cfg_wdata[VEC_W-1:0];
				CFG_PLANE_Y: plane_y_q <= cfg_wdata[VEC_W-1:0];
				default: ;
			endcase
		end
	end

	// input fields
	logic [TILE_W-1:0]       in_cx, in_cy;
	logic [CELL_W-1:0]       in_val;
	logic signed [SCL_W-1:0] in_scl;
	assign in_cx  = in_data[5:0];
	assign in_cy  = in_data[11:6];
	assign in_val = in_data[19:12];
	assign in_scl = in_data[37:20];

	// clearing pass counter
	logic [ADDR_W-1:0] clr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.op == OP_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// map memory
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;
	logic [TILE_W-1:0] tile_x_q, tile_y_q;

	assign ram_we    = (cmd.op == OP_CLEAR) || (cmd.op == OP_WRITE);
	assign ram_waddr = (cmd.op == OP_CLEAR) ? clr_q : {in_cx, in_cy};
	assign ram_wdata = (cmd.op == OP_CLEAR) ? '0 : in_val;
	assign ram_raddr = {tile_x_q, tile_y_q};

	grdc_ram #(.WIDTH(CELL_W), .DEPTH(MAP_DEPTH)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// plane times scalar, registered ahead of the sum
	logic signed [PROD_W-1:0] prod_x_s1, prod_y_s1;
	always_ff @(posedge clk) begin
		if (cmd.op == OP_CAST) begin
			prod_x_s1 <= plane_x_q * in_scl;
			prod_y_s1 <= plane_y_q * in_scl;
		end
	end

	// ray components; the arithmetic shift gives the floor
	logic signed [RAY_W-1:0] rx, ry;
	assign rx = RAY_W'(dir_x_q) + RAY_W'(prod_x_s1 >>> FRAC);
	assign ry = RAY_W'(dir_y_q) + RAY_W'(prod_y_s1 >>> FRAC);

	// per-axis state
	logic [MAG_W-1:0]   mag_x_q, mag_y_q;
	logic               pos_dir_x_q, pos_dir_y_q;
	logic               inf_x_q, inf_y_q;
	logic [DELTA_W-1:0] delta_x_q, delta_y_q;
	logic [DIST_W-1:0]  dist_x_q, dist_y_q;

	// shared divider
	logic               div_busy;
	logic [DELTA_W-1:0] div_q;
	grdc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_DIV_START),
		.divisor  (cmd.sel ? mag_y_q : mag_x_q),
		.busy     (div_busy),
		.quotient (div_q)
	);

	// first edge distance: two 17x17 partial products
	logic [FRAC-1:0]    frac_sel;
	logic [EDGE_W-1:0]  edge_frac;
	logic [DELTA_W-1:0] delta_sel;
	logic [2*EDGE_W-1:0] p_lo_s1;
	logic [2*EDGE_W-1:0] p_hi;
	logic [DIST_W-1:0]   edge_dist;

	assign frac_sel  = cmd.sel ? pos_y_q[FRAC-1:0] : pos_x_q[FRAC-1:0];
	assign delta_sel = cmd.sel ? delta_y_q : delta_x_q;
	assign edge_frac = (cmd.sel ? pos_dir_y_q : pos_dir_x_q)
		? (EDGE_W'(1) << FRAC) - EDGE_W'(frac_sel) : EDGE_W'(frac_sel);
	assign p_hi      = edge_frac * delta_sel[DELTA_W-1:FRAC];
	assign edge_dist = DIST_W'(p_hi) + DIST_W'(p_lo_s1 >> FRAC);

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EDGE_LO) begin
			p_lo_s1 <= edge_frac * EDGE_W'(delta_sel[FRAC-1:0]);
		end
	end

	// stepping decision: an infinite distance never wins
	logic step_x;
	assign step_x = !inf_x_q && (inf_y_q || (dist_x_q < dist_y_q));

	logic [STEP_CW-1:0] n_q;
	logic               side_q, oob_q, hit_q;
	logic [CELL_W-1:0]  wall_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_SUM: begin
				mag_x_q     <= rx[RAY_W-1] ? MAG_W'(-rx) : MAG_W'(rx);
				mag_y_q     <= ry[RAY_W-1] ? MAG_W'(-ry) : MAG_W'(ry);
				pos_dir_x_q <= !rx[RAY_W-1];
				pos_dir_y_q <= !ry[RAY_W-1];
				inf_x_q     <= rx == '0;
				inf_y_q     <= ry == '0;
				tile_x_q    <= pos_x_q[POS_W-1:FRAC];
				tile_y_q    <= pos_y_q[POS_W-1:FRAC];
				oob_q       <= 1'b0;
			end
			OP_DIV_TAKE: begin
				if (cmd.sel) delta_y_q <= div_q;
				else         delta_x_q <= div_q;
			end
			OP_EDGE_HI: begin
				if (cmd.sel) dist_y_q <= edge_dist;
				else         dist_x_q <= edge_dist;
			end
			OP_STEP: begin
				if (step_x) begin
					dist_x_q <= dist_x_q + DIST_W'(delta_x_q);
					side_q   <= 1'b0;
					if (pos_dir_x_q) begin
						oob_q    <= tile_x_q == TILE_W'(MAP_W - 1);
						tile_x_q <= tile_x_q + 1'b1;
					end else begin
						oob_q    <= tile_x_q == '0;
						tile_x_q <= tile_x_q - 1'b1;
					end
				end else begin
					side_q <= 1'b1;
					if (!inf_y_q) begin
						dist_y_q <= dist_y_q + DIST_W'(delta_y_q);
						if (pos_dir_y_q) begin
							oob_q    <= tile_y_q == TILE_W'(MAP_H - 1);
							tile_y_q <= tile_y_q + 1'b1;
						end else begin
							oob_q    <= tile_y_q == '0;
							tile_y_q <= tile_y_q - 1'b1;
						end
					end else begin
						oob_q <= 1'b0;
					end
				end
			end
			OP_CHECK: begin
				hit_q  <= !oob_q && (ram_rdata != '0);
				wall_q <= ram_rdata;
			end
			default: ;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (cmd.op == OP_SUM) begin
			n_q <= '0;
		end else if (cmd.op == OP_STEP) begin
			n_q <= n_q + 1'b1;
		end
	end

	// result: hit edge distance less one step, saturated
	logic [DIST_W-1:0]  res_diff;
	logic               res_inf;
	logic [OUT_D_W-1:0] res_dist;

	assign res_inf  = side_q ? inf_y_q : inf_x_q;
	assign res_diff = side_q ? dist_y_q - DIST_W'(delta_y_q) : dist_x_q - DIST_W'(delta_x_q);
	assign res_dist = (res_inf || (res_diff[DIST_W-1:OUT_D_W] != '0))
		? '1 : res_diff[OUT_D_W-1:0];

	// output register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_LOAD) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			if (hit_q) begin
				out_data_q <= {6'b0, 1'b0, side_q, wall_q, res_dist};
			end else begin
				out_data_q <= {6'b0, 1'b1, 1'b0, {CELL_W{1'b0}}, {OUT_D_W{1'b1}}};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// status to the controller
	assign sts.clr_last   = clr_q == '1;
	assign sts.div_busy   = div_busy;
	assign sts.out_full   = out_valid_q;
	assign sts.oob        = oob_q;
	assign sts.wall_nz    = ram_rdata != '0;
	assign sts.steps_last = n_q == STEP_CW'(MAX_STEPS);

`ifndef SYNTHESIS
	a_steps_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= STEP_CW'(MAX_STEPS))
		else $error("step counter ran past the step limit");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_DIV_START |=> div_busy)
		else $error("divider did not start");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_LOAD |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");
`endif

endmodule

[sv/grdc_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences map clearing, ray setup, stepping and result hand-off.
// Depends on grdc_pkg.
module grdc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_cast,
	output logic           in_ready,
	input  logic           out_ready,
	input  grdc_pkg::sts_t sts,
	output grdc_pkg::cmd_t cmd
);
	import grdc_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SUM,
		ST_DIVX,
		ST_DIVX_W,
		ST_EDGEX_LO,
		ST_EDGEX_HI,
		ST_DIVY,
		ST_DIVY_W,
		ST_EDGEY_LO,
		ST_EDGEY_HI,
		ST_STEP,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} state_t;

	state_t state_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR:    if (sts.clr_last) state_q <= ST_IDLE;
				ST_IDLE:     if (in_valid && in_cast) state_q <= ST_SUM;
				ST_SUM:      state_q <= ST_DIVX;
				ST_DIVX:     state_q <= ST_DIVX_W;
				ST_DIVX_W:   if (!sts.div_busy) state_q <= ST_EDGEX_LO;
				ST_EDGEX_LO: state_q <= ST_EDGEX_HI;
				ST_EDGEX_HI: state_q <= ST_DIVY;
				ST_DIVY:     state_q <= ST_DIVY_W;
				ST_DIVY_W:   if (!sts.div_busy) state_q <= ST_EDGEY_LO;
				ST_EDGEY_LO: state_q <= ST_EDGEY_HI;
				ST_EDGEY_HI: state_q <= ST_STEP;
				ST_STEP:     state_q <= ST_READ;
				ST_READ:     state_q <= ST_CHECK;
				ST_CHECK: begin
					if (sts.oob || sts.wall_nz || sts.steps_last) state_q <= ST_DONE;
					else state_q <= ST_STEP;
				end
				ST_DONE:     if (!sts.out_full || out_ready) state_q <= ST_IDLE;
				default:     state_q <= ST_CLEAR;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd.op  = OP_NONE;
		cmd.sel = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.op = OP_CLEAR;
			ST_IDLE: begin
				if (in_valid) cmd.op = in_cast ? OP_CAST : OP_WRITE;
			end
			ST_SUM:      cmd.op = OP_SUM;
			ST_DIVX:     cmd.op = OP_DIV_START;
			ST_DIVX_W:   if (!sts.div_busy) cmd.op = OP_DIV_TAKE;
			ST_EDGEX_LO: cmd.op = OP_EDGE_LO;
			ST_EDGEX_HI: cmd.op = OP_EDGE_HI;
			ST_DIVY: begin
				cmd.op  = OP_DIV_START;
				cmd.sel = 1'b1;
			end
			ST_DIVY_W: begin
				cmd.sel = 1'b1;
				if (!sts.div_busy) cmd.op = OP_DIV_TAKE;
			end
			ST_EDGEY_LO: begin
				cmd.op  = OP_EDGE_LO;
				cmd.sel = 1'b1;
			end
			ST_EDGEY_HI: begin
				cmd.op  = OP_EDGE_HI;
				cmd.sel = 1'b1;
			end
			ST_STEP:  cmd.op = OP_STEP;
			ST_CHECK: cmd.op = OP_CHECK;
			ST_DONE:  if (!sts.out_full || out_ready) cmd.op = OP_LOAD;
			default: ;
		endcase
	end

	assign in_ready = state_q == ST_IDLE;

endmodule

[sv/grid_ray_dda_caster_unit.sv]
`timescale 1ns / 1ps
// Top level of the grid ray caster: stream ports, controller and datapath.
// Depends on grdc_pkg, grdc_ctrl and grdc_datapath.

// After reset the 64 x 64 tile map is swept to zero, during which no item is
// taken (configuration writes are). A cast item runs its setup on the shared
// divider, which forms one reciprocal bit per cycle for each axis in turn,
// then takes a step, a map read and a check per tile step for up to 128 steps,
// and then loads the result register. A result waiting in that register does
// not hold off the next item until a later result needs the register.
module grid_ray_dda_caster_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// cell_x[5:0], cell_y[11:6], cell_value[19:12], scalar[37:20], zero[39:38]
	input  logic [grdc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// cmd[0]
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// distance[23:0], wall_id[31:24], side[32], escaped[33], zero[39:34]
	output logic [grdc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [grdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [grdc_pkg::POS_W-1:0]      cfg_data
);
	import grdc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	grdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_cast   (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	grdc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

[test/grid_ray_dda_caster_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for grid_ray_dda_caster_unit: tile map loads and ray casts
// checked against an in-bench DDA traversal model. Depends on grdc_pkg and the RTL.
module grid_ray_dda_caster_unit_tb;
	import grdc_pkg::*;

	localparam longint unsigned DIST_INF = 64'd1 << 62;
	localparam longint CYCLE_LIMIT = 4000000;
	localparam int SETTLE_CYCLES = 700;   // longer than one cast of 128 steps
	localparam int HOLD_CYCLES = 2500;

	typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

	// highest field first, so the struct lines up with tdata[33:0]
	typedef struct packed {
		logic        escaped;
		logic        hit_side;
		logic [7:0]  wall_id;
		logic [23:0] distance;
	} ray_res_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  idx;
		logic [21:0] cdata;
		logic        cmd;
		logic [5:0]  cx;
		logic [5:0]  cy;
		logic [7:0]  val;
		logic [17:0] scalar;
		logic        typed;
		ray_res_t    res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [POS_W-1:0] cfg_data = '0;

	grid_ray_dda_caster_unit dut (.*);

	// clock, period 8 ns
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// model state
	logic [7:0] tiles [0:MAP_W-1][0:MAP_H-1];
	longint unsigned cam_px, cam_py;
	longint cam_dx, cam_dy, cam_plx, cam_ply;

	ray_res_t cast_results_q [$];
	int errors = 0;
	longint cycles = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_cnt = 0;
	int rx_seg = 0;
	bit rx_stall_mode = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	row_t rows [$];

	function automatic longint unsigned edge_mul(longint unsigned a, longint unsigned b);
		return a * (b >> FRAC) + ((a * (b & 64'hFFFF)) >> FRAC);
	endfunction

	function automatic longint unsigned dist_add(longint unsigned a, longint unsigned b);
		longint unsigned s;
		s = a + b;
		return (s >= DIST_INF) ? DIST_INF : s;
	endfunction

	function automatic void axis_init(input longint unsigned pos, input longint r,
			output longint tile, output longint stp,
			output longint unsigned edist, output longint unsigned delta);
		longint unsigned frac, mag;
		frac = pos & 64'hFFFF;
		tile = longint'(pos >> FRAC);
		if (r == 0) begin
			stp = 0;
			edist = DIST_INF;
			delta = DIST_INF;
		end else begin
			mag = (r < 0) ? longint'(-r) : longint'(r);
			delta = (64'd1 << (2 * FRAC)) / mag;
			if (r > 0) begin
				stp = 1;
				edist = edge_mul((64'd1 << FRAC) - frac, delta);
			end else begin
				stp = -1;
				edist = edge_mul(frac, delta);
			end
		end
	endfunction

	// DDA traversal of the model map for one cast
	function automatic ray_res_t trace_ray(logic [17:0] scalar);
		longint s, rx, ry, tx, ty, sx, sy;
		longint unsigned dxd, dyd, ddx, ddy, hd, hdel, d;
		logic side;
		logic [7:0] wall;
		bit hit;
		ray_res_t r;
		s = $signed(scalar);
		rx = cam_dx + ((cam_plx * s) >>> FRAC);
		ry = cam_dy + ((cam_ply * s) >>> FRAC);
		axis_init(cam_px, rx, tx, sx, dxd, ddx);
		axis_init(cam_py, ry, ty, sy, dyd, ddy);
		side = 1'b0;
		wall = '0;
		hit = 1'b0;
		for (int n = 0; n < MAX_STEPS; n++) begin
			if (dxd < dyd) begin
				tx += sx;
				dxd = dist_add(dxd, ddx);
				side = 1'b0;
			end else begin
				ty += sy;
				dyd = dist_add(dyd, ddy);
				side = 1'b1;
			end
			if (tx < 0 || tx >= MAP_W || ty < 0 || ty >= MAP_H)
				break;
			wall = tiles[tx][ty];
			if (wall != 0) begin
				hit = 1'b1;
				break;
			end
		end
		if (!hit) begin
			r = '{distance: 24'hFFFFFF, wall_id: 8'd0, hit_side: 1'b0, escaped: 1'b1};
		end else begin
			hd = side ? dyd : dxd;
			hdel = side ? ddy : ddx;
			if (hd >= DIST_INF || hdel >= DIST_INF)
				d = 64'hFFFFFF;
			else begin
				d = hd - hdel;
				if (d > 64'hFFFFFF)
					d = 64'hFFFFFF;
			end
			r = '{distance: d[23:0], wall_id: wall, hit_side: side, escaped: 1'b0};
		end
		return r;
	endfunction

	function automatic void cfg_apply(logic [2:0] idx, logic [21:0] data);
		case (idx)
			CFG_POS_X:   cam_px = data;
			CFG_POS_Y:   cam_py = data;
			CFG_DIR_X:   cam_dx = $signed(data[18:0]);
			CFG_DIR_Y:   cam_dy = $signed(data[18:0]);
			CFG_PLANE_X: cam_plx = $signed(data[18:0]);
			CFG_PLANE_Y: cam_ply = $signed(data[18:0]);
			default: ;
		endcase
	endfunction

	function automatic row_t mk_item(logic cmd, logic [5:0] cx, logic [5:0] cy, logic [7:0] v,
			logic [17:0] sc, logic typed, ray_res_t res);
		row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.cmd = cmd;
		r.cx = cx;
		r.cy = cy;
		r.val = v;
		r.scalar = sc;
		r.typed = typed;
		r.res = res;
		return r;
	endfunction

	function automatic row_t mk_cfg(logic [2:0] idx, logic [21:0] data);
		row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.cdata = data;
		return r;
	endfunction

	// sign-extended vector value for the 22-bit write bus
	function automatic logic [21:0] vec22(longint v);
		logic [21:0] w;
		w = v[21:0];
		return w;
	endfunction

	// one item transfer, with bursts and gaps on the sender side
	task automatic send_item(logic cmd, logic [5:0] cx, logic [5:0] cy, logic [7:0] v,
			logic [17:0] sc, logic typed, ray_res_t res);
		@(negedge clk);
		while (gap_left > 0) begin
			s_axis_tvalid <= 1'b0;
			gap_left--;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {2'b00, sc, v, cy, cx};
		do @(posedge clk); while (!s_axis_tready);
		if (cmd == 1'b0)
			tiles[cx][cy] = v;
		else
			cast_results_q.push_back(typed ? res : trace_ray(sc));
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = $urandom_range(0, 20);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		end
	endtask

	// register write, only once the block has gone idle
	task automatic write_reg(logic [2:0] idx, logic [21:0] data);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (cast_results_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_apply(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver: stall pattern plus one long hold-off
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_cnt <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_seg == 0) begin
				rx_seg <= $urandom_range(5, 60);
				rx_stall_mode <= $urandom_range(0, 1);
			end else
				rx_seg <= rx_seg - 1;
			m_axis_tready <= rx_stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
		end
	end

	// result check on every output transfer
	always @(posedge clk) begin
		ray_res_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[33:0];
			if (cast_results_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $time, got);
			end else begin
				want = cast_results_q.pop_front();
				if (got.distance !== want.distance) begin
					errors++;
					$display("%0t: distance exp %h got %h", $time, want.distance, got.distance);
				end
				if (got.wall_id !== want.wall_id) begin
					errors++;
					$display("%0t: wall_id exp %h got %h", $time, want.wall_id, got.wall_id);
				end
				if (got.hit_side !== want.hit_side) begin
					errors++;
					$display("%0t: side exp %b got %b", $time, want.hit_side,
						got.hit_side);
				end
				if (got.escaped !== want.escaped) begin
					errors++;
					$display("%0t: escaped exp %b got %b", $time, want.escaped, got.escaped);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		ray_res_t esc, none;
		row_t r;
		logic [17:0] sc;
		logic [21:0] cv [0:5];
		int pick;
		esc = '{distance: 24'hFFFFFF, wall_id: 8'd0, hit_side: 1'b0, escaped: 1'b1};
		none = '0;
		for (int x = 0; x < MAP_W; x++)
			for (int y = 0; y < MAP_H; y++)
				tiles[x][y] = '0;
		cam_px = 98304;
		cam_py = 98304;
		cam_dx = 65536;
		cam_dy = 0;
		cam_plx = 0;
		cam_ply = -43254;

		// directed stimulus; typed results only where obvious
		rows.push_back(mk_item(1, 6'h3F, 6'h3F, 8'hFF, 18'h00000, 1, esc));   // empty map
		rows.push_back(mk_item(1, 0, 0, 0, 18'h10000, 1, esc));
		rows.push_back(mk_item(1, 0, 0, 0, 18'h30000, 1, esc));
		rows.push_back(mk_item(0, 3, 1, 8'd5, 18'h3FFFF, 0, none));
		rows.push_back(mk_item(1, 0, 0, 0, 18'h00000, 1,
			'{distance: 24'd98304, wall_id: 8'd5, hit_side: 1'b0, escaped: 1'b0}));
		rows.push_back(mk_item(0, 0, 0, 8'd1, 18'h0, 0, none));
		rows.push_back(mk_item(0, 63, 63, 8'd255, 18'h0, 0, none));
		rows.push_back(mk_item(0, 0, 63, 8'd128, 18'h0, 0, none));
		rows.push_back(mk_item(0, 63, 0, 8'd7, 18'h0, 0, none));
		rows.push_back(mk_item(1, 0, 0, 0, 18'd10000, 0, none));
		rows.push_back(mk_item(1, 0, 0, 0, 18'h3FFFF & -18'd30000, 0, none));
		rows.push_back(mk_item(0, 3, 1, 8'd0, 18'h0, 0, none));              // clear it again
		rows.push_back(mk_item(1, 0, 0, 0, 18'h00000, 0, none));
		// zero ray: step limit, then a hit at infinite distance in its own cell
		rows.push_back(mk_cfg(CFG_DIR_X, 22'd0));
		rows.push_back(mk_cfg(CFG_PLANE_Y, 22'd0));
		rows.push_back(mk_item(1, 0, 0, 0, 18'h05555, 1, esc));
		rows.push_back(mk_item(0, 1, 1, 8'd9, 18'h0, 0, none));
		rows.push_back(mk_item(1, 0, 0, 0, 18'h0, 1,
			'{distance: 24'hFFFFFF, wall_id: 8'd9, hit_side: 1'b1, escaped: 1'b0}));
		// indexes past the register list have no effect
		rows.push_back(mk_cfg(3'd6, 22'h3FFFFF));
		rows.push_back(mk_cfg(3'd7, 22'h2AAAAA));
		rows.push_back(mk_item(1, 0, 0, 0, 18'h10000, 1,
			'{distance: 24'hFFFFFF, wall_id: 8'd9, hit_side: 1'b1, escaped: 1'b0}));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			r = rows[i];
			if (r.kind == ROW_CFG)
				write_reg(r.idx, r.cdata);
			else
				send_item(r.cmd, r.cx, r.cy, r.val, r.scalar, r.typed, r.res);
		end

		// random phases, each under its own camera setting
		for (int ph = 0; ph < 12; ph++) begin
			for (int k = 0; k < 6; k++) begin
				if (ph == 0)
					cv[k] = (k < 2) ? 22'd0 : vec22(-131072);
				else if (ph == 1)
					cv[k] = (k < 2) ? 22'h3FFFFF : vec22(131072);
				else if (k < 2)
					cv[k] = ($urandom_range(0, 4) == 0) ? 22'($urandom)
						: 22'($urandom_range(65536, 63 * 65536 - 1));
				else if ($urandom_range(0, 5) == 0)
					cv[k] = 22'd0;
				else
					cv[k] = vec22(longint'($urandom_range(0, 262144)) - 131072);
			end
			for (int k = 0; k < 6; k++)
				write_reg(3'(k), cv[k]);
			if (ph == 3)
				hold_req = 1'b1;
			for (int n = 0; n < 155; n++) begin
				pick = $urandom_range(0, 9);
				case ($urandom_range(0, 7))
					0: sc = 18'h10000;
					1: sc = 18'h30000;
					default: sc = 18'(longint'($urandom_range(0, 131072)) - 65536);
				endcase
				if (pick < 3)
					send_item(0, 6'($urandom), 6'($urandom),
						($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom), 18'($urandom),
						0, none);
				else
					send_item(1, 6'($urandom), 6'($urandom), 8'($urandom), sc, 0, none);
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (cast_results_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && cast_results_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[grid_ray_dda_caster_unit.f]
sv/grdc_pkg.sv
sv/grdc_ram.sv
sv/grdc_div.sv
sv/grdc_datapath.sv
sv/grdc_ctrl.sv
sv/grid_ray_dda_caster_unit.sv
test/grid_ray_dda_caster_unit_tb.sv
